FILE: hdl/sged_pkg.sv
package sged_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int MAX_TEXT    = 65535;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int POS_W       = 16;
    localparam int SCORE_W     = 8;
    localparam int CFG_ADDR_W  = 1;
    localparam logic [SCORE_W-1:0] SCORE_CAP = 8'd255;
    localparam logic [CFG_ADDR_W-1:0] REG_INDEL = 1'b0;
    localparam logic [SCORE_W-1:0] INDEL_RESET = 8'd1;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_TEXT = 2'd1,
        OP_EMIT = 2'd2,
        OP_NONE = 2'd3
    } t_opcode;

    typedef struct packed {
        logic load;
        logic text_start;
        logic text_drop;
        logic step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic len_zero;
        logic last_col;
        logic text_full;
        logic out_busy;
    } t_stat;

    function automatic logic [SCORE_W-1:0] sat_add(input logic [SCORE_W-1:0] a,
                                                   input logic [SCORE_W-1:0] b);
        logic [SCORE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SCORE_W] ? SCORE_CAP : s[SCORE_W-1:0];
    endfunction

endpackage

FILE: hdl/sged_in_if.sv
interface sged_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] symbol;

    modport source (output valid, output opcode, output symbol, input ready);
    modport sink (input valid, input opcode, input symbol, output ready);
endinterface

FILE: hdl/sged_out_if.sv
interface sged_out_if;
    logic        valid;
    logic        ready;
    logic [6:0]  distance;
    logic [15:0] position;
    logic        overflow;

    modport source (output valid, output distance, output position, output overflow,
                    input ready);
    modport sink (input valid, input distance, input position, input overflow,
                  output ready);
endinterface

FILE: hdl/semiglobal_edit_distance_search_core.sv
// channel   dir  beat fields                          handshake
// i_item    in   opcode[1:0], symbol[7:0]             valid/ready
// o_result  out  distance[6:0], position[15:0], ovf   valid/ready
// apb       in   gap cost at 0x0                      psel/penable, pready=1
// Loads and end items need no row pass; a text symbol that is not dropped runs a row pass over a non-empty pattern,
// one row cell per cycle through the shared cell unit and row memory.
// Reset (synchronous, active low) clears lengths, counters and flags; indel=1.
// Input stalls while a cell row is in progress or a result beat is stalled.
module semiglobal_edit_distance_search_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sged_in_if.sink                         i_item,
    sged_out_if.source                      o_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sged_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [sged_pkg::SCORE_W-1:0] r_indel;
    sged_pkg::t_cmd               cmd;
    sged_pkg::t_stat              stat;

    assign pready = 1'b1;
    assign prdata = (paddr == sged_pkg::REG_INDEL) ? {24'd0, r_indel} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_indel <= sged_pkg::INDEL_RESET;
        end else if (psel && penable && pwrite && paddr == sged_pkg::REG_INDEL) begin
            r_indel <= pwdata[7:0];
        end
    end

    sged_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_item.valid),
        .i_opcode (i_item.opcode),
        .i_stat   (stat),
        .o_ready  (i_item.ready),
        .o_cmd    (cmd)
    );

    sged_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_symbol (i_item.symbol),
        .i_indel  (r_indel),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result)
    );

    a_step_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step |-> !i_item.ready) else $error("input accepted during row");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.text_start, cmd.text_drop, cmd.emit}))
        else $error("conflicting commands");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(cmd.emit)) else $error("result without end item");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> o_result.distance <= 7'(sged_pkg::MAX_PATTERN))
        else $error("distance out of range");

endmodule

FILE: hdl/sged_ctrl.sv
module sged_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [1:0]     i_opcode,
    input  sged_pkg::t_stat i_stat,
    output logic           o_ready,
    output sged_pkg::t_cmd  o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_ROW
    } t_state;

    t_state r_state;
    logic   accept;

    assign o_ready = (r_state == S_IDLE) && !i_stat.out_busy;
    assign accept  = i_valid && o_ready;

    always_comb begin
        o_cmd = '0;
        if (accept) begin
            case (sged_pkg::t_opcode'(i_opcode))
                sged_pkg::OP_LOAD: o_cmd.load = 1'b1;
                sged_pkg::OP_TEXT: begin
                    o_cmd.text_drop  = i_stat.text_full;
                    o_cmd.text_start = !i_stat.text_full;
                end
                sged_pkg::OP_EMIT: o_cmd.emit = 1'b1;
                default: ;
            endcase
        end
        if (r_state == S_ROW) o_cmd.step = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (o_cmd.text_start && !i_stat.len_zero) r_state <= S_ROW;
                S_ROW:  if (i_stat.last_col) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: hdl/sged_dp.sv
module sged_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [7:0]                  i_symbol,
    input  logic [sged_pkg::SCORE_W-1:0] i_indel,
    input  sged_pkg::t_cmd               i_cmd,
    output sged_pkg::t_stat              o_stat,
    sged_out_if.source                  o_result
);

    logic [7:0]                       pat_mem [sged_pkg::MAX_PATTERN];
    logic [sged_pkg::SCORE_W-1:0]     row_mem [sged_pkg::MAX_PATTERN];
    logic [7:0]                       r_pat_q;
    logic [sged_pkg::SCORE_W-1:0]     r_row_q;

    logic [sged_pkg::LEN_W-1:0]       r_len;
    logic [sged_pkg::LEN_W-1:0]       r_col;
    logic [sged_pkg::POS_W-1:0]       r_tc;
    logic [sged_pkg::LEN_W-1:0]       r_best;
    logic [sged_pkg::POS_W-1:0]       r_pos;
    logic                             r_ovf;
    logic                             r_first;
    logic [7:0]                       r_sym;
    logic [sged_pkg::SCORE_W-1:0]     r_left;
    logic [sged_pkg::SCORE_W-1:0]     r_diag;
    logic [sged_pkg::SCORE_W-1:0]     r_ramp;
    logic                             r_out_v;
    logic [sged_pkg::LEN_W-1:0]       r_out_dist;
    logic [sged_pkg::POS_W-1:0]       r_out_pos;
    logic                             r_out_ovf;

    logic [sged_pkg::IDX_W-1:0]       rd_addr;
    logic [14:0]                      ramp_prod;
    logic [sged_pkg::SCORE_W-1:0]     ramp_len;
    logic [sged_pkg::LEN_W-1:0]       init_best;
    logic [sged_pkg::LEN_W-1:0]       base_best;
    logic [sged_pkg::SCORE_W-1:0]     up;
    logic [sged_pkg::SCORE_W-1:0]     gap;
    logic [sged_pkg::SCORE_W-1:0]     sub;
    logic [sged_pkg::SCORE_W-1:0]     node;
    logic [sged_pkg::POS_W-1:0]       tc_inc;

    assign rd_addr   = i_cmd.text_start ? '0 : r_col[sged_pkg::IDX_W-1:0];
    assign ramp_prod = {8'd0, r_len} * {7'd0, i_indel};
    assign ramp_len  = (ramp_prod > 15'(sged_pkg::SCORE_CAP)) ? sged_pkg::SCORE_CAP
                                                               : ramp_prod[7:0];
    assign init_best = ({1'b0, r_len} > ramp_len) ? ramp_len[sged_pkg::LEN_W-1:0] : r_len;
    assign base_best = (r_tc == '0) ? init_best : r_best;
    assign tc_inc    = r_tc + 1'b1;

    assign up   = r_first ? r_ramp : r_row_q;
    assign gap  = sged_pkg::sat_add((up < r_left) ? up : r_left, i_indel);
    assign sub  = sged_pkg::sat_add(r_diag, {7'd0, r_pat_q != r_sym});
    assign node = (gap < sub) ? gap : sub;

    assign o_stat.len_zero  = (r_len == '0);
    assign o_stat.last_col  = (r_col == r_len);
    assign o_stat.text_full = (r_tc == sged_pkg::POS_W'(sged_pkg::MAX_TEXT));
    assign o_stat.out_busy  = r_out_v && !o_result.ready;

    assign o_result.valid    = r_out_v;
    assign o_result.distance = r_out_dist;
    assign o_result.position = r_out_pos;
    assign o_result.overflow = r_out_ovf;

    always_ff @(posedge i_clk) begin
        r_pat_q <= pat_mem[rd_addr];
        r_row_q <= row_mem[rd_addr];
        if (i_cmd.load && r_tc == '0 && r_len != sged_pkg::LEN_W'(sged_pkg::MAX_PATTERN)) begin
            pat_mem[r_len[sged_pkg::IDX_W-1:0]] <= i_symbol;
        end
        if (i_cmd.step) begin
            row_mem[sged_pkg::IDX_W'(r_col - 1'b1)] <= node;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.text_start) begin
            r_sym   <= i_symbol;
            r_first <= (r_tc == '0);
            r_left  <= '0;
            r_diag  <= '0;
            r_ramp  <= i_indel;
        end
        if (i_cmd.step) begin
            r_left <= node;
            r_diag <= up;
            r_ramp <= sged_pkg::sat_add(r_ramp, i_indel);
        end
        if (i_cmd.emit) begin
            if (r_tc < sged_pkg::POS_W'(r_len)) begin
                r_out_dist <= r_len;
                r_out_pos  <= '0;
            end else begin
                r_out_dist <= r_best;
                r_out_pos  <= r_pos;
            end
            r_out_ovf <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_col   <= '0;
            r_tc    <= '0;
            r_best  <= '0;
            r_pos   <= '0;
            r_ovf   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_cmd.emit) r_out_v <= 1'b1;
            else if (o_result.ready) r_out_v <= 1'b0;
            if (i_cmd.load && r_tc == '0) begin
                if (r_len == sged_pkg::LEN_W'(sged_pkg::MAX_PATTERN)) r_ovf <= 1'b1;
                else r_len <= r_len + 1'b1;
            end
            if (i_cmd.text_drop) r_ovf <= 1'b1;
            if (i_cmd.text_start) begin
                r_col <= sged_pkg::LEN_W'(1);
                if (r_tc == '0) begin
                    r_best <= init_best;
                    r_pos  <= '0;
                end
                if (r_len == '0) begin
                    r_tc <= tc_inc;
                    if (base_best != '0) begin
                        r_best <= '0;
                        r_pos  <= tc_inc;
                    end
                end
            end
            if (i_cmd.step) begin
                r_col <= r_col + 1'b1;
                if (r_col == r_len) begin
                    r_tc <= tc_inc;
                    if (node < {1'b0, r_best}) begin
                        r_best <= node[sged_pkg::LEN_W-1:0];
                        r_pos  <= tc_inc;
                    end
                end
            end
            if (i_cmd.emit) begin
                r_tc    <= '0;
                r_best  <= '0;
                r_pos   <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

endmodule

FILE: test/sged_distance_checker.sv
`timescale 1ns / 100ps

module sged_distance_checker
    import sged_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sged_in_if                    in_mon,
    sged_out_if                   out_mon,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output int                    n_err,
    output int                    n_wait
);

    typedef struct packed {
        logic [6:0]  distance;
        logic [15:0] position;
        logic        overflow;
    } t_match;

    t_match      awaited[$];
    logic [7:0]  indel;
    logic [7:0]  pat[MAX_PATTERN];
    logic [7:0]  row[MAX_PATTERN+1];
    int unsigned plen;
    int unsigned tcount;
    int unsigned best_d;
    int unsigned best_p;
    logic        ovf;
    int          errs = 0;

    assign n_err  = errs;
    assign n_wait = awaited.size();

    function automatic logic [7:0] clip(int unsigned s);
        return (s > 255) ? 8'd255 : s[7:0];
    endfunction

    function void start_text();
        for (int c = 0; c <= plen; c++) row[c] = clip(c * indel);
        best_d = plen;
        best_p = 0;
        if (row[plen] < best_d) best_d = row[plen];
    endfunction

    function void fold_symbol(logic [7:0] s);
        logic [7:0] diag, left, up, gap, sub, node;
        diag   = row[0];
        left   = 8'd0;
        row[0] = 8'd0;
        for (int c = 1; c <= plen; c++) begin
            up   = row[c];
            gap  = clip(int'((up < left) ? up : left) + int'(indel));
            sub  = clip(int'(diag) + ((pat[c-1] != s) ? 1 : 0));
            node = (gap < sub) ? gap : sub;
            diag = up;
            row[c] = node;
            left = node;
        end
    endfunction

    function void predict(t_opcode op, logic [7:0] s);
        t_match m;
        case (op)
            OP_LOAD: begin
                if (tcount == 0) begin
                    if (plen >= MAX_PATTERN) begin
                        ovf = 1'b1;
                    end else begin
                        pat[plen] = s;
                        plen++;
                        row[plen] = clip(plen * indel);
                    end
                end
            end
            OP_TEXT: begin
                if (tcount >= MAX_TEXT) begin
                    ovf = 1'b1;
                end else begin
                    if (tcount == 0) start_text();
                    fold_symbol(s);
                    tcount++;
                    if (row[plen] < best_d) begin
                        best_d = row[plen];
                        best_p = tcount;
                    end
                end
            end
            OP_EMIT: begin
                if (tcount == 0) start_text();
                if (tcount < plen) begin
                    m.distance = plen[6:0];
                    m.position = 16'd0;
                end else begin
                    m.distance = best_d[6:0];
                    m.position = best_p[15:0];
                end
                m.overflow = ovf;
                awaited.push_back(m);
                tcount = 0;
                best_d = 0;
                best_p = 0;
                ovf    = 1'b0;
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_match m;
        if (!i_rst_n) begin
            indel  = INDEL_RESET;
            plen   = 0;
            tcount = 0;
            best_d = 0;
            best_p = 0;
            ovf    = 1'b0;
            for (int c = 0; c <= MAX_PATTERN; c++) row[c] = 8'd0;
            awaited.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == REG_INDEL)
                indel = pwdata[7:0];
            if (in_mon.valid && in_mon.ready)
                predict(t_opcode'(in_mon.opcode), in_mon.symbol);
            if (out_mon.valid && out_mon.ready) begin
                if (awaited.size() == 0) begin
                    $error("result beat with nothing expected");
                    errs++;
                end else begin
                    m = awaited.pop_front();
                    if (out_mon.distance !== m.distance) begin
                        $error("distance: expected %0d, got %0d", m.distance, out_mon.distance);
                        errs++;
                    end
                    if (out_mon.position !== m.position) begin
                        $error("position: expected %0d, got %0d", m.position, out_mon.position);
                        errs++;
                    end
                    if (out_mon.overflow !== m.overflow) begin
                        $error("overflow: expected %0d, got %0d", m.overflow, out_mon.overflow);
                        errs++;
                    end
                end
            end
        end
    end

endmodule

FILE: test/semiglobal_edit_distance_search_core_tb.sv
`timescale 1ns / 100ps

module semiglobal_edit_distance_search_core_tb;
    import sged_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel, penable, pwrite, pready;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata, prdata;
    int                    n_err, n_wait;
    int                    items = 0;
    int                    idle_cycles = 0;
    logic [7:0]            pat[$];
    bit                    calm = 1'b0;
    bit                    squeeze = 1'b0;
    bit                    squeezed = 1'b0;

    sged_in_if  item_ch ();
    sged_out_if res_ch ();

    semiglobal_edit_distance_search_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_result(res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sged_distance_checker chk (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_mon (item_ch),
        .out_mon(res_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .pready (pready),
        .paddr  (paddr),
        .pwdata (pwdata),
        .n_err  (n_err),
        .n_wait (n_wait)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] pick_symbol();
        logic [7:0] bases[4];
        bases = '{8'h41, 8'h43, 8'h47, 8'h54};
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        return bases[$urandom_range(0, 3)];
    endfunction

    task automatic send(t_opcode op, logic [7:0] s);
        int g;
        g = pick_gap();
        if (g > 0) begin
            item_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        item_ch.valid  <= 1'b1;
        item_ch.opcode <= op;
        item_ch.symbol <= s;
        do @(posedge i_clk); while (!item_ch.ready);
        items++;
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        while (n_wait != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic set_indel(logic [7:0] v);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_INDEL;
        pwdata  <= {24'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_symbols(int n);
        logic [7:0] s;
        for (int k = 0; k < n; k++) begin
            s = pick_symbol();
            send(OP_LOAD, s);
            if (pat.size() < MAX_PATTERN) pat.push_back(s);
        end
    endtask

    task automatic text_beat(logic [7:0] s, bit noisy, inout bit started);
        if (noisy && started && $urandom_range(0, 7) == 0)
            send(($urandom_range(0, 1) != 0) ? OP_NONE : OP_LOAD, pick_symbol());
        send(OP_TEXT, s);
        started = 1'b1;
    endtask

    task automatic search_round(bit noisy);
        bit started;
        int r, n;
        started = 1'b0;
        if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(0, pat.size() + 3);
            for (int k = 0; k < n; k++) text_beat(pick_symbol(), noisy, started);
        end else begin
            n = $urandom_range(0, 4);
            for (int k = 0; k < n; k++) text_beat(pick_symbol(), noisy, started);
            foreach (pat[k]) begin
                r = $urandom_range(0, 9);
                if (r == 0) continue;
                if (r == 1) text_beat(pick_symbol(), noisy, started);
                else if (r == 2) begin
                    text_beat(pick_symbol(), noisy, started);
                    text_beat(pat[k], noisy, started);
                end else text_beat(pat[k], noisy, started);
            end
            n = $urandom_range(0, 4);
            for (int k = 0; k < n; k++) text_beat(pick_symbol(), noisy, started);
        end
        send(OP_EMIT, pick_symbol());
    endtask

    initial begin
        int g;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (squeeze && !squeezed) begin
                squeezed = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else begin
                g = pick_gap();
                if (g > 0) begin
                    res_ch.ready <= 1'b0;
                    repeat (g) @(posedge i_clk);
                end
            end
            res_ch.ready <= 1'b1;
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] choices[6];
        i_rst_n        <= 1'b0;
        item_ch.valid  <= 1'b0;
        item_ch.opcode <= OP_NONE;
        item_ch.symbol <= 8'd0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= REG_INDEL;
        pwdata         <= 32'd0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pattern
        send(OP_EMIT, 8'hFF);
        send(OP_TEXT, 8'h00);
        send(OP_TEXT, 8'hFF);
        send(OP_NONE, 8'h5A);
        send(OP_EMIT, 8'h00);
        // extreme symbols
        send(OP_LOAD, 8'h00);
        pat.push_back(8'h00);
        send(OP_TEXT, 8'hFF);
        send(OP_TEXT, 8'h00);
        send(OP_LOAD, 8'hAA);
        send(OP_TEXT, 8'hFF);
        send(OP_EMIT, 8'h00);
        send(OP_LOAD, 8'hFF);
        pat.push_back(8'hFF);
        send(OP_EMIT, 8'h00);
        send(OP_TEXT, 8'h00);
        send(OP_EMIT, 8'h00);
        set_indel(8'd0);
        send(OP_TEXT, 8'hFF);
        send(OP_TEXT, 8'h55);
        send(OP_EMIT, 8'h00);
        set_indel(8'd255);
        send(OP_EMIT, 8'h00);
        send(OP_TEXT, 8'h00);
        send(OP_TEXT, 8'hFF);
        send(OP_TEXT, 8'h00);
        send(OP_EMIT, 8'h00);
        set_indel(8'd1);

        // output held off while emits keep coming
        squeeze = 1'b1;
        for (int k = 0; k < 12; k++) send(OP_EMIT, pick_symbol());
        drain();

        choices = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd255, 8'd1};
        while (items < 1100) begin
            if ($urandom_range(0, 3) == 0) begin
                choices[5] = 8'($urandom_range(0, 255));
                set_indel(choices[$urandom_range(0, 5)]);
            end
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) < 6) load_symbols(0);
            else load_symbols($urandom_range(1, 3));
            search_round($urandom_range(0, 3) == 0);
        end

        // pattern overflow
        load_symbols(MAX_PATTERN + 2 - pat.size());
        search_round(1'b0);
        send(OP_EMIT, 8'h00);

        drain();
        repeat (100) @(posedge i_clk);
        if (n_err == 0 && n_wait == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
